// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ACD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in %m");
`define ACD_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen in %m");
`else
`define ACD_ASSERT(label, clk, rst_n, prop)
`define ACD_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/acd_pkg.sv
// types and constants of the stick to pad mapper
`default_nettype none
package acd_pkg;

    typedef struct packed {
        logic [7:0] stick_x;
        logic [7:0] stick_y;
    } t_stick_in;

    typedef struct packed {
        logic [3:0] pad_dirs;
        logic       stick_active;
    } t_pad_out;

    // direction bit positions in pad_dirs
    localparam int DIR_UP    = 0;
    localparam int DIR_RIGHT = 1;
    localparam int DIR_DOWN  = 2;
    localparam int DIR_LEFT  = 3;

    // cone test slots: horizontal axis, vertical axis, up diagonal, down diagonal
    localparam int SLOT_H = 0;
    localparam int SLOT_V = 1;
    localparam int SLOT_U = 2;
    localparam int SLOT_N = 3;
    localparam int N_SLOT = 4;

    localparam logic signed [8:0] DEAD_ZONE = 9'sd64;
    localparam logic signed [8:0] CENTRE    = 9'sd128;
    localparam logic [15:0]       MAG_MIN   = 16'd8029;

    // 10^14 = TEN14_HI * 2^24 + TEN14_LO
    localparam logic [23:0] TEN14_LO = 24'd8011776;
    localparam logic [22:0] TEN14_HI = 23'd5960464;
    // cos^2(16 deg) * 10^14 = COS2_HI * 2^24 + COS2_LO
    localparam logic [23:0] COS2_LO  = 24'd9420497;
    localparam logic [22:0] COS2_HI  = 23'd5507612;

    typedef struct packed {
        logic side_r;
        logic side_l;
        logic vert_u;
        logic vert_d;
        logic du_pos;
        logic dn_pos;
        logic active;
    } t_flags;

    typedef struct packed {
        logic [7:0] ax;
        logic [7:0] ay;
        logic [8:0] du_mag;
        logic [8:0] dn_mag;
        t_flags     flags;
    } t_prep;

    typedef struct packed {
        logic [N_SLOT-1:0][16:0] dd;
        t_flags                  flags;
    } t_sq;

endpackage
`default_nettype wire

// File: rtl/acd_prep.sv
// first stage: centring, dead zone, magnitudes and diagonal dot products
`default_nettype none
module acd_prep import acd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_vld,
    output logic      o_rdy,
    input  t_stick_in i_data,
    output logic      o_vld,
    input  logic      i_rdy,
    output t_prep     o_data
);

    logic signed [8:0] x;
    logic signed [8:0] y;
    logic signed [8:0] x_neg;
    logic signed [8:0] y_neg;
    logic              x_dead;
    logic              y_dead;
    logic [9:0]        ax_ext;
    logic [9:0]        y_ext;
    logic [9:0]        du;
    logic [9:0]        dn;
    t_prep             n_data;
    t_prep             r_data;
    logic              r_vld;

    always_comb begin
        x      = $signed({1'b0, i_data.stick_x}) - CENTRE;
        y      = CENTRE - $signed({1'b0, i_data.stick_y});
        x_neg  = -x;
        y_neg  = -y;
        x_dead = (x > -DEAD_ZONE) && (x < DEAD_ZONE);
        y_dead = (y > -DEAD_ZONE) && (y < DEAD_ZONE);

        n_data.ax = x_dead ? 8'd0 : (x[8] ? x_neg[7:0] : x[7:0]);
        n_data.ay = y_dead ? 8'd0 : (y[8] ? y_neg[7:0] : y[7:0]);

        // same formulas serve both sides since the side dot product is |x|
        ax_ext = {2'b00, n_data.ax};
        y_ext  = y_dead ? 10'd0 : {y[8], y};
        du     = ax_ext + y_ext;
        dn     = ax_ext - y_ext;

        n_data.du_mag       = du[8:0];
        n_data.dn_mag       = dn[8:0];
        n_data.flags.side_r = !x_dead && !x[8];
        n_data.flags.side_l = !x_dead && x[8];
        n_data.flags.vert_u = !y_dead && !y[8];
        n_data.flags.vert_d = !y_dead && y[8];
        n_data.flags.du_pos = !du[9] && (du != 10'd0);
        n_data.flags.dn_pos = !dn[9] && (dn != 10'd0);
        n_data.flags.active = !x_dead || !y_dead;
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule
`default_nettype wire

// File: rtl/acd_square.sv
// second stage: squares of the four dot products
`default_nettype none
module acd_square import acd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    output logic  o_rdy,
    input  t_prep i_data,
    output logic  o_vld,
    input  logic  i_rdy,
    output t_sq   o_data
);

    logic [15:0] sq_x;
    logic [15:0] sq_y;
    logic [17:0] sq_u;
    logic [17:0] sq_n;
    t_sq         n_data;
    t_sq         r_data;
    logic        r_vld;

    always_comb begin
        sq_x = {8'd0, i_data.ax} * {8'd0, i_data.ax};
        sq_y = {8'd0, i_data.ay} * {8'd0, i_data.ay};
        sq_u = {9'd0, i_data.du_mag} * {9'd0, i_data.du_mag};
        sq_n = {9'd0, i_data.dn_mag} * {9'd0, i_data.dn_mag};

        n_data.dd[SLOT_H] = {1'b0, sq_x};
        n_data.dd[SLOT_V] = {1'b0, sq_y};
        // a diagonal magnitude is at most 256, so its square fits 17 bits
        n_data.dd[SLOT_U] = sq_u[16:0];
        n_data.dd[SLOT_N] = sq_n[16:0];
        n_data.flags      = i_data.flags;
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule
`default_nettype wire

// File: rtl/acd_cone.sv
// cone tests: exact dd * 10^14 against cos^2 * m, split into partial products
`default_nettype none
module acd_cone import acd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_vld,
    output logic     o_rdy,
    input  t_sq      i_data,
    output logic     o_vld,
    input  logic     i_rdy,
    output t_pad_out o_data
);

    // stage a: magnitude and partial products of the left-hand sides
    logic [15:0] n_m_a;
    logic [40:0] n_lo   [N_SLOT];
    logic [39:0] n_hi   [N_SLOT];
    logic [15:0] r_m_a;
    logic [40:0] r_lo   [N_SLOT];
    logic [39:0] r_hi   [N_SLOT];
    t_flags      r_fl_a;
    logic        r_vld_a;
    logic        rdy_a;

    // stage b: summed left-hand sides and partial products of the right-hand side
    logic [63:0] n_lhs  [N_SLOT];
    logic [39:0] n_mc_lo;
    logic [38:0] n_mc_hi;
    logic [63:0] r_lhs  [N_SLOT];
    logic [39:0] r_mc_lo;
    logic [38:0] r_mc_hi;
    logic [15:0] r_m_b;
    t_flags      r_fl_b;
    logic        r_vld_b;
    logic        rdy_b;

    logic [63:0] rhs_axis;
    logic [63:0] rhs_diag;
    logic        pass_h;
    logic        pass_v;
    logic        pass_u;
    logic        pass_n;
    logic [3:0]  dirs;

    always_comb begin
        n_m_a = i_data.dd[SLOT_H][15:0] + i_data.dd[SLOT_V][15:0];
        for (int i = 0; i < N_SLOT; i++) begin
            n_lo[i] = {24'd0, i_data.dd[i]} * {17'd0, TEN14_LO};
            n_hi[i] = {23'd0, i_data.dd[i]} * {17'd0, TEN14_HI};
        end
    end

    assign rdy_a = !r_vld_a || rdy_b;
    assign o_rdy = rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (rdy_a) begin
            r_vld_a <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_vld) begin
            r_m_a  <= n_m_a;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_fl_a <= i_data.flags;
        end
    end

    always_comb begin
        for (int i = 0; i < N_SLOT; i++) begin
            n_lhs[i] = {r_hi[i], 24'd0} + {23'd0, r_lo[i]};
        end
        n_mc_lo = {24'd0, r_m_a} * {16'd0, COS2_LO};
        n_mc_hi = {23'd0, r_m_a} * {16'd0, COS2_HI};
    end

    assign rdy_b = !r_vld_b || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (rdy_b) begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_vld_a) begin
            r_lhs   <= n_lhs;
            r_mc_lo <= n_mc_lo;
            r_mc_hi <= n_mc_hi;
            r_m_b   <= r_m_a;
            r_fl_b  <= r_fl_a;
        end
    end

    // cos^2 * m stays below 2^62, so doubling it for the diagonals cannot overflow
    always_comb begin
        rhs_axis = {1'b0, r_mc_hi, 24'd0} + {24'd0, r_mc_lo};
        rhs_diag = {rhs_axis[62:0], 1'b0};

        pass_h = r_lhs[SLOT_H] >= rhs_axis;
        pass_v = r_lhs[SLOT_V] >= rhs_axis;
        pass_u = r_fl_b.du_pos && (r_lhs[SLOT_U] >= rhs_diag);
        pass_n = r_fl_b.dn_pos && (r_lhs[SLOT_N] >= rhs_diag);

        dirs = 4'd0;
        if (r_m_b >= MAG_MIN) begin
            if (r_fl_b.side_r || r_fl_b.side_l) begin
                if (pass_h || pass_u || pass_n) begin
                    if (r_fl_b.side_r) begin
                        dirs[DIR_RIGHT] = 1'b1;
                    end else begin
                        dirs[DIR_LEFT] = 1'b1;
                    end
                end
                if (pass_u) begin
                    dirs[DIR_UP] = 1'b1;
                end
                if (pass_n) begin
                    dirs[DIR_DOWN] = 1'b1;
                end
            end
            if (pass_v && r_fl_b.vert_u) begin
                dirs[DIR_UP] = 1'b1;
            end
            if (pass_v && r_fl_b.vert_d) begin
                dirs[DIR_DOWN] = 1'b1;
            end
        end

        o_data.pad_dirs     = dirs;
        o_data.stick_active = r_fl_b.active;
    end

    assign o_vld = r_vld_b;

endmodule
`default_nettype wire

// File: rtl/analog_stick_to_dpad.sv
// top level of the analog stick to digital pad mapper
//
// Usage: each input beat on i_in_* carries one raw stick sample (x, y, 128 is
// centre, lower y is up). Each accepted beat yields exactly one output beat on
// o_out_* with the four pad direction bits and the stick activity flag, in
// the order the samples came in.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// Pipeline: a sample is centred as it is accepted and registered, then passes
// the squaring stage, two partial product stages and the output register
// before it is presented on o_out_valid. Throughput: one sample per clock
// while the output is not stalled, set by the fully pipelined datapath; the
// widest step is a 17 by 24 bit constant multiply.
// Each stage loads whenever it is empty or its successor moves on, so bubbles
// are squeezed out and the pipeline holds up to five samples.
// Stall: while i_out_ready is low the output beat is held; o_in_ready drops
// only when every stage is occupied.
// Reset: i_rst_n is synchronous, active low, and empties the pipeline; no
// beat is presented until new samples are taken in.
`default_nettype none
`include "assert_macros.svh"
module analog_stick_to_dpad import acd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_stick_in i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_pad_out  o_out_data
);

    logic     prep_vld;
    logic     prep_rdy;
    t_prep    prep_data;
    logic     sq_vld;
    logic     sq_rdy;
    t_sq      sq_data;
    logic     cone_vld;
    logic     cone_rdy;
    t_pad_out cone_data;
    logic     r_out_vld;
    t_pad_out r_out;

    acd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in_valid),
        .o_rdy   (o_in_ready),
        .i_data  (i_in_data),
        .o_vld   (prep_vld),
        .i_rdy   (prep_rdy),
        .o_data  (prep_data)
    );

    acd_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (prep_vld),
        .o_rdy   (prep_rdy),
        .i_data  (prep_data),
        .o_vld   (sq_vld),
        .i_rdy   (sq_rdy),
        .o_data  (sq_data)
    );

    acd_cone u_cone (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sq_vld),
        .o_rdy   (sq_rdy),
        .i_data  (sq_data),
        .o_vld   (cone_vld),
        .i_rdy   (cone_rdy),
        .o_data  (cone_data)
    );

    // output register, parts the receiver from the compare logic
    assign cone_rdy = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (cone_rdy) begin
            r_out_vld <= cone_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cone_rdy && cone_vld) begin
            r_out <= cone_data;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // a sample inside the dead zone on both axes yields no pad directions
    `ACD_ASSERT(a_idle_no_dirs, i_clk, i_rst_n, (o_out_valid && !o_out_data.stick_active) |-> (o_out_data.pad_dirs == 4'd0))
    // opposite directions exclude each other
    `ACD_NEVER(a_no_up_down, i_clk, i_rst_n, o_out_valid && o_out_data.pad_dirs[DIR_UP] && o_out_data.pad_dirs[DIR_DOWN])
    `ACD_NEVER(a_no_left_right, i_clk, i_rst_n, o_out_valid && o_out_data.pad_dirs[DIR_LEFT] && o_out_data.pad_dirs[DIR_RIGHT])
    // back pressure reaches the input only through a stalled output beat
    `ACD_ASSERT(a_stall_source, i_clk, i_rst_n, !o_in_ready |-> (o_out_valid && !i_out_ready))

endmodule
`default_nettype wire
